// File: rtl/tea_pkg.sv
package tea_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned TEA_ROUNDS = 32;
	localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e3669b9;

	localparam logic OP_ENC = 1'b0;
	localparam logic OP_DEC = 1'b1;

	// one block in flight, with its key
	typedef struct packed {
		logic              op;
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] z;
		logic [WORD_W-1:0] k0;
		logic [WORD_W-1:0] k1;
		logic [WORD_W-1:0] k2;
		logic [WORD_W-1:0] k3;
	} tea_item_t;

	// pipeline advance and the valid bit that comes with the item
	typedef struct packed {
		logic adv;
		logic valid;
	} tea_ctrl_t;

	function automatic logic [WORD_W-1:0] tea_mix(
		input logic [WORD_W-1:0] x,
		input logic [WORD_W-1:0] sum,
		input logic [WORD_W-1:0] ka,
		input logic [WORD_W-1:0] kb
	);
		logic [WORD_W-1:0] t_shl;
		logic [WORD_W-1:0] t_sum;
		logic [WORD_W-1:0] t_shr;
		t_shl = (x << 4) + ka;
		t_sum = x + sum;
		t_shr = (x >> 5) + kb;
		return t_shl ^ t_sum ^ t_shr;
	endfunction

endpackage

// File: rtl/tea_stage.sv
module tea_stage import tea_pkg::*; #(
	parameter int unsigned ROUNDS = TEA_ROUNDS,
	parameter int unsigned IDX    = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  tea_ctrl_t ctrl,
	input  tea_item_t item_in,
	output logic      valid_s1,
	output tea_item_t item_s1
);

	localparam int unsigned RND  = IDX / 2;
	localparam bit          HALF = (IDX % 2) == 1;
	// running sum for this round is a constant of the stage position
	localparam logic [63:0] ENC_PROD = 64'(RND + 1) * 64'(TEA_DELTA);
	localparam logic [63:0] DEC_PROD = 64'(ROUNDS - RND) * 64'(TEA_DELTA);
	localparam logic [WORD_W-1:0] ENC_SUM = ENC_PROD[WORD_W-1:0];
	localparam logic [WORD_W-1:0] DEC_SUM = DEC_PROD[WORD_W-1:0];

	logic              is_enc;
	logic              upd_y;
	logic [WORD_W-1:0] x;
	logic [WORD_W-1:0] ka;
	logic [WORD_W-1:0] kb;
	logic [WORD_W-1:0] sum;
	logic [WORD_W-1:0] mix;
	logic [WORD_W-1:0] target;
	logic [WORD_W-1:0] res;
	tea_item_t         item_nxt;

	always_comb begin
		is_enc = (item_in.op == OP_ENC);
		// encrypt updates y first, decrypt undoes z first
		upd_y  = (is_enc == !HALF);
		x      = upd_y ? item_in.z  : item_in.y;
		ka     = upd_y ? item_in.k0 : item_in.k2;
		kb     = upd_y ? item_in.k1 : item_in.k3;
		sum    = is_enc ? ENC_SUM : DEC_SUM;
		mix    = tea_mix(x, sum, ka, kb);
		target = upd_y ? item_in.y : item_in.z;
		res    = is_enc ? (target + mix) : (target - mix);
		item_nxt = item_in;
		if (upd_y) begin
			item_nxt.y = res;
		end else begin
			item_nxt.z = res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctrl.adv) begin
			valid_s1 <= ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv && ctrl.valid) begin
			item_s1 <= item_nxt;
		end
	end

endmodule

// File: rtl/tea_out_reg.sv
module tea_out_reg import tea_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  tea_ctrl_t         ctrl,
	input  tea_item_t         item_in,
	input  logic              m_tready,
	output logic              m_tvalid,
	output logic [2*WORD_W-1:0] m_tdata
);

	logic                valid_q;
	logic [2*WORD_W-1:0] data_q;
	logic                load;

	assign load = ctrl.adv && ctrl.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= {item_in.z, item_in.y};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule

// File: rtl/tea_block_cipher_core_unit.sv
// tea-structured block cipher engine (non-standard delta), 64-bit block, 128-bit key, 32 rounds by default
//
// input channel s_*: one item per block; s_tuser carries the operation
// (0 encrypt, 1 decrypt), s_tdata the two block halves and the four key words.
// output channel m_*: one item per input item, in order, with the two
// processed halves.
//
// each round is split over two pipeline stages (one half-round each), so there
// are 2*ROUNDS stages followed by an output register. an accepted item passes
// through every stage and then the output register before it shows on m_tvalid;
// a new item can be taken every cycle while s_tready is high.
//
// reset clears every valid bit; the pipeline comes out empty and ready.
// when the receiver stalls, the pipeline keeps moving until a result reaches
// the last stage with the output register still full; only then does the whole
// pipeline hold and s_tready drop, so items keep being accepted into bubbles.
module tea_block_cipher_core_unit import tea_pkg::*; #(
	parameter int unsigned ROUNDS = TEA_ROUNDS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// block_left, block_right, key_word0, key_word1, key_word2, key_word3
	input  logic [6*WORD_W-1:0] s_tdata,
	// op
	input  logic [0:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// out_left, out_right
	output logic [2*WORD_W-1:0] m_tdata
);

	localparam int unsigned NSTAGE = 2 * ROUNDS;

	logic                  adv;
	logic [NSTAGE-1:0]     stage_valid;
	tea_item_t             stage_item [NSTAGE];
	tea_item_t             in_item;

	// hold only when the last stage has a result and the output slot is busy
	assign adv      = !stage_valid[NSTAGE-1] || !m_tvalid || m_tready;
	assign s_tready = adv;

	always_comb begin
		in_item.op = s_tuser[0];
		in_item.y  = s_tdata[WORD_W-1:0];
		in_item.z  = s_tdata[2*WORD_W-1:WORD_W];
		in_item.k0 = s_tdata[3*WORD_W-1:2*WORD_W];
		in_item.k1 = s_tdata[4*WORD_W-1:3*WORD_W];
		in_item.k2 = s_tdata[5*WORD_W-1:4*WORD_W];
		in_item.k3 = s_tdata[6*WORD_W-1:5*WORD_W];
	end

	for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
		tea_ctrl_t ctrl;
		tea_item_t item_src;
		if (i == 0) begin : g_first
			assign ctrl     = '{adv: adv, valid: s_tvalid};
			assign item_src = in_item;
		end else begin : g_rest
			assign ctrl     = '{adv: adv, valid: stage_valid[i-1]};
			assign item_src = stage_item[i-1];
		end

		tea_stage #(
			.ROUNDS (ROUNDS),
			.IDX    (i)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.item_in  (item_src),
			.valid_s1 (stage_valid[i]),
			.item_s1  (stage_item[i])
		);
	end

	tea_ctrl_t out_ctrl;
	assign out_ctrl = '{adv: adv, valid: stage_valid[NSTAGE-1]};

	tea_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (out_ctrl),
		.item_in  (stage_item[NSTAGE-1]),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

	// a held pipeline keeps its valid pattern
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> stage_valid == $past(stage_valid))
		else $error("pipeline valid bits moved while held");

	// an accepted item lands in the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> stage_valid[0])
		else $error("accepted item missing from first stage");

	// a result leaving the last stage is presented next cycle
	a_exit_presented: assert property (@(posedge clk) disable iff (!arst_n)
		adv && stage_valid[NSTAGE-1] |=> m_tvalid)
		else $error("result from last stage not presented");

	// a full last stage behind a stalled output blocks new input
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && stage_valid[NSTAGE-1] |-> !s_tready)
		else $error("input accepted while pipeline full and output stalled");

endmodule
